// ===== rtl/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg: shared types and constants of the field sweep sequencer
// Operation, event, register index and phase codes, divider request and
// response structs, and the fixed constants of the setpoint and duty math.
// ----------------------------------------------------------------------------
package fss_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_START_V   = 3'd0;
  localparam logic [2:0] CFG_STEP_V    = 3'd1;
  localparam logic [2:0] CFG_STOP_V    = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_NEEDED    = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT   = 3'd5;
  localparam logic [2:0] CFG_CURRENT   = 3'd6;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_STARTED  = 4'd1,
    EV_APPLIED  = 4'd2,
    EV_WAITING  = 4'd3,
    EV_SETTLED  = 4'd4,
    EV_TIMEOUT  = 4'd5,
    EV_DATA     = 4'd6,
    EV_LAST     = 4'd7,
    EV_ABORTED  = 4'd8
  } event_t;

  typedef enum logic [1:0] {
    PH_SET  = 2'd0,
    PH_STAB = 2'd1,
    PH_MEAS = 2'd2,
    PH_RSVD = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DUTY,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam logic [10:0] V_MAX = 11'd600;
  localparam logic [22:0] R_MAX = 23'd4194303;

  // resistance magnitude = (|125*(vp-vm)| + cur) / (2*cur)
  localparam int DIVIDEND_W = 23;
  localparam int DIVISOR_W  = 11;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam logic [22:0] RES_SCALE = 23'd125;

  // duty = floor((setp*51 + 60) / 120), division by reciprocal multiply
  localparam logic [14:0] DUTY_MUL   = 15'd51;
  localparam logic [14:0] DUTY_BIAS  = 15'd60;
  localparam logic [15:0] DUTY_RECIP = 16'd34953;
  localparam int          DUTY_SHIFT = 22;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/fss_divider.sv =====
// ----------------------------------------------------------------------------
// fss_divider: radix-2 restoring divider
// One quotient bit per cycle; busy drops once all bits are done.
// ----------------------------------------------------------------------------
module fss_divider (
  input  logic              clk,
  input  logic              rst,
  input  fss_pkg::div_req_t req,
  output fss_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic [fss_pkg::DIV_CNT_W-1:0]   count;
  logic [fss_pkg::DIVISOR_W-1:0]   divisor;
  logic [fss_pkg::DIVISOR_W-1:0]   rem;
  logic [fss_pkg::DIVIDEND_W-1:0]  quo;
  logic [fss_pkg::DIVISOR_W:0]     trial;
  logic [fss_pkg::DIVISOR_W:0]     diff;
  logic                            fits;

  assign trial = {rem, quo[fss_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= fss_pkg::DIV_CNT_W'(fss_pkg::DIV_STEPS);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == fss_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[fss_pkg::DIVISOR_W-1:0] : trial[fss_pkg::DIVISOR_W-1:0];
      quo <= {quo[fss_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/fss_duty.sv =====
// ----------------------------------------------------------------------------
// fss_duty: setpoint to pwm duty scaler
// Two stages: scale and bias, then reciprocal multiply for the divide by 120.
// ----------------------------------------------------------------------------
module fss_duty (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [9:0] setpoint,
  output logic       done,
  output logic [7:0] duty
);

  logic        stage1_vld;
  logic [14:0] scaled;
  logic [30:0] prod;

  assign prod = {16'd0, scaled} * {15'd0, fss_pkg::DUTY_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_vld <= 1'b0;
      done       <= 1'b0;
    end else begin
      stage1_vld <= start;
      done       <= stage1_vld;
    end
  end

  always_ff @(posedge clk) begin
    scaled <= {5'd0, setpoint} * fss_pkg::DUTY_MUL + fss_pkg::DUTY_BIAS;
    // duty holds until the next item is scaled
    if (stage1_vld) begin
      duty <= 8'(prod >> fss_pkg::DUTY_SHIFT);
    end
  end

endmodule

// ===== rtl/field_sweep_sequencer_unit.sv =====
// flow: an accepted item runs through the evaluate and duty states, data events then
//   through the serial resistance divider; the result goes to the output register
// one item at a time: in_ready returns once the result is in the output register;
//   a held result does not stop the next accept, but stalls that item in ST_DONE
// reset: synchronous active-high rst clears sweep state, restores register
//   defaults and empties the output register
// ----------------------------------------------------------------------------
// field_sweep_sequencer_unit: magnet field sweep sequencer
// Sequences set-voltage, stabilize and measure phases per tick item and
// reports one result item per input item, with delta-mode resistance.
// ----------------------------------------------------------------------------
module field_sweep_sequencer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [31:0]        now_ms,
  input  logic signed [15:0] hall_sample,
  input  logic signed [15:0] plus_sample,
  input  logic signed [15:0] minus_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         event_res,
  output logic [9:0]         magnet_setpoint,
  output logic [7:0]         pwm_duty,
  output logic [15:0]        point_number,
  output logic signed [15:0] field_value,
  output logic signed [22:0] resistance,
  output logic signed [15:0] plus_value,
  output logic signed [15:0] minus_value,
  output logic               running,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  // configuration registers
  logic [9:0]  reg_start_v;
  logic [9:0]  reg_step_v;
  logic [9:0]  reg_stop_v;
  logic [14:0] reg_threshold;
  logic [7:0]  reg_needed;
  logic [19:0] reg_timeout;
  logic [9:0]  reg_current;

  // sweep state
  fss_pkg::phase_t phase, phase_next;
  logic            active, active_next;
  logic [15:0]     point_index, point_next;
  logic [10:0]     present_voltage, volt_next;
  logic [15:0]     last_field, last_next;
  logic [7:0]      stable_run, run_next;
  logic [31:0]     phase_start_ms, pstart_next;

  // sequencer and working registers
  fss_pkg::state_t state, state_next;
  fss_pkg::event_t ev, ev_next;
  logic            meas, meas_next;
  logic            res_neg;
  logic            cur_zero;
  logic [9:0]      setp, setp_next;
  logic [15:0]     pnum;
  logic [1:0]      item_op;
  logic [31:0]     item_now;
  logic [15:0]     item_hall;
  logic [15:0]     item_plus;
  logic [15:0]     item_minus;

  logic eval_en;
  logic load_out;
  logic accept;

  // output register
  fss_pkg::event_t out_event;

  // datapath helpers
  logic [16:0] hall_diff, hall_abs;
  logic        abs_small;
  logic [7:0]  run_inc, run_stab;
  logic        settled, timed_out;
  logic [31:0] elapsed;
  logic [10:0] volt_step, volt_pick;
  logic [16:0] pm_diff, pm_abs;
  logic [22:0] num_abs;
  logic        is_data;
  logic [22:0] res_mag;
  logic [22:0] res_val;

  fss_pkg::div_req_t div_req;
  fss_pkg::div_rsp_t div_rsp;
  logic              duty_done;
  logic [7:0]        duty_val;

  fss_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fss_duty u_duty (
    .clk      (clk),
    .rst      (rst),
    .start    (eval_en),
    .setpoint (setp_next),
    .done     (duty_done),
    .duty     (duty_val)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_start_v   <= 10'd0;
      reg_step_v    <= 10'd10;
      reg_stop_v    <= 10'd600;
      reg_threshold <= 15'd8;
      reg_needed    <= 8'd5;
      reg_timeout   <= 20'd5000;
      reg_current   <= 10'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fss_pkg::CFG_START_V:   reg_start_v   <= cfg_data[9:0];
        fss_pkg::CFG_STEP_V:    reg_step_v    <= cfg_data[9:0];
        fss_pkg::CFG_STOP_V:    reg_stop_v    <= cfg_data[9:0];
        fss_pkg::CFG_THRESHOLD: reg_threshold <= cfg_data[14:0];
        fss_pkg::CFG_NEEDED:    reg_needed    <= cfg_data[7:0];
        fss_pkg::CFG_TIMEOUT:   reg_timeout   <= cfg_data;
        fss_pkg::CFG_CURRENT:   reg_current   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // stabilize phase arithmetic
  assign hall_diff = {item_hall[15], item_hall} - {last_field[15], last_field};
  assign hall_abs  = hall_diff[16] ? (~hall_diff + 17'd1) : hall_diff;
  assign abs_small = hall_abs < {2'd0, reg_threshold};
  assign run_inc   = (stable_run == 8'hFF) ? stable_run : stable_run + 8'd1;
  assign run_stab  = abs_small ? run_inc : 8'd0;
  assign settled   = run_stab >= reg_needed;
  assign elapsed   = item_now - phase_start_ms;
  assign timed_out = elapsed >= {12'd0, reg_timeout};
  assign volt_step = present_voltage + {1'b0, reg_step_v};

  always_comb begin
    active_next = active;
    phase_next  = phase;
    point_next  = point_index;
    volt_next   = present_voltage;
    last_next   = last_field;
    run_next    = stable_run;
    pstart_next = phase_start_ms;
    ev_next     = fss_pkg::EV_NONE;
    meas_next   = 1'b0;
    if (item_op == fss_pkg::OP_START) begin
      if (!active) begin
        active_next = 1'b1;
        point_next  = 16'd1;
        volt_next   = {1'b0, reg_start_v};
        last_next   = item_hall;
        run_next    = 8'd0;
        pstart_next = item_now;
        phase_next  = fss_pkg::PH_SET;
        ev_next     = fss_pkg::EV_STARTED;
      end
    end else if (item_op == fss_pkg::OP_ABORT) begin
      active_next = 1'b0;
      ev_next     = fss_pkg::EV_ABORTED;
    end else if (active) begin
      case (phase)
        fss_pkg::PH_STAB: begin
          last_next = item_hall;
          run_next  = run_stab;
          if (settled || timed_out) begin
            ev_next     = settled ? fss_pkg::EV_SETTLED : fss_pkg::EV_TIMEOUT;
            phase_next  = fss_pkg::PH_MEAS;
            pstart_next = item_now;
          end else begin
            ev_next = fss_pkg::EV_WAITING;
          end
        end
        fss_pkg::PH_MEAS: begin
          meas_next  = 1'b1;
          ev_next    = fss_pkg::EV_DATA;
          volt_next  = volt_step;
          point_next = point_index + 16'd1;
          if (volt_step > {1'b0, reg_stop_v}) begin
            active_next = 1'b0;
            ev_next     = fss_pkg::EV_LAST;
          end else begin
            phase_next  = fss_pkg::PH_SET;
            pstart_next = item_now;
          end
        end
        default: begin
          // set-voltage phase, reserved code behaves the same
          last_next   = item_hall;
          run_next    = 8'd0;
          pstart_next = item_now;
          phase_next  = fss_pkg::PH_STAB;
          ev_next     = fss_pkg::EV_APPLIED;
        end
      endcase
    end
  end

  // data events report the voltage of the point, before stepping
  assign volt_pick = meas_next ? present_voltage : volt_next;
  always_comb begin
    if (ev_next == fss_pkg::EV_NONE || ev_next == fss_pkg::EV_ABORTED) begin
      setp_next = 10'd0;
    end else if (volt_pick > fss_pkg::V_MAX) begin
      setp_next = fss_pkg::V_MAX[9:0];
    end else begin
      setp_next = volt_pick[9:0];
    end
  end

  // resistance dividend, rounded half away from zero on the magnitude
  assign pm_diff = {item_plus[15], item_plus} - {item_minus[15], item_minus};
  assign pm_abs  = pm_diff[16] ? (~pm_diff + 17'd1) : pm_diff;
  assign num_abs = {6'd0, pm_abs} * fss_pkg::RES_SCALE;

  assign div_req.start    = eval_en && meas_next;
  assign div_req.dividend = num_abs + {13'd0, reg_current};
  assign div_req.divisor  = {reg_current, 1'b0};

  always_comb begin
    state_next = state;
    unique case (state)
      fss_pkg::ST_IDLE: if (in_valid) state_next = fss_pkg::ST_EVAL;
      fss_pkg::ST_EVAL: state_next = fss_pkg::ST_DUTY;
      fss_pkg::ST_DUTY: begin
        if (duty_done) state_next = meas ? fss_pkg::ST_DIV : fss_pkg::ST_DONE;
      end
      fss_pkg::ST_DIV:  if (!div_rsp.busy) state_next = fss_pkg::ST_DONE;
      fss_pkg::ST_DONE: if (!out_valid || out_ready) state_next = fss_pkg::ST_IDLE;
      default: state_next = fss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == fss_pkg::ST_IDLE);
    eval_en  = (state == fss_pkg::ST_EVAL);
    load_out = (state == fss_pkg::ST_DONE) && (!out_valid || out_ready);
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= fss_pkg::ST_IDLE;
      phase           <= fss_pkg::PH_SET;
      active          <= 1'b0;
      point_index     <= 16'd0;
      present_voltage <= 11'd0;
      last_field      <= 16'd0;
      stable_run      <= 8'd0;
      phase_start_ms  <= 32'd0;
      ev              <= fss_pkg::EV_NONE;
      meas            <= 1'b0;
      out_valid       <= 1'b0;
      out_event       <= fss_pkg::EV_NONE;
      running         <= 1'b0;
    end else begin
      state <= state_next;
      if (eval_en) begin
        phase           <= phase_next;
        active          <= active_next;
        point_index     <= point_next;
        present_voltage <= volt_next;
        last_field      <= last_next;
        stable_run      <= run_next;
        phase_start_ms  <= pstart_next;
        ev              <= ev_next;
        meas            <= meas_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        out_event <= ev;
        running   <= active;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op    <= operation;
      item_now   <= now_ms;
      item_hall  <= hall_sample;
      item_plus  <= plus_sample;
      item_minus <= minus_sample;
    end
    if (eval_en) begin
      setp     <= setp_next;
      pnum     <= point_index;
      res_neg  <= pm_diff[16];
      cur_zero <= (reg_current == 10'd0);
    end
  end

  assign is_data = (ev == fss_pkg::EV_DATA) || (ev == fss_pkg::EV_LAST);
  assign res_mag = (div_rsp.quotient > fss_pkg::R_MAX) ? fss_pkg::R_MAX : div_rsp.quotient;

  always_comb begin
    if (!is_data || cur_zero) begin
      res_val = 23'd0;
    end else if (res_neg) begin
      res_val = ~res_mag + 23'd1;
    end else begin
      res_val = res_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      magnet_setpoint <= setp;
      pwm_duty        <= duty_val;
      point_number    <= is_data ? pnum : 16'd0;
      field_value     <= is_data ? item_hall : 16'sd0;
      resistance      <= res_val;
      plus_value      <= is_data ? item_plus : 16'sd0;
      minus_value     <= is_data ? item_minus : 16'sd0;
    end
  end

  assign event_res = out_event;

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != fss_pkg::EV_DATA && event_res != fss_pkg::EV_LAST
      |-> point_number == 16'd0 && resistance == 23'sd0)
    else $error("non-data result carries data fields");

  a_abort_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == fss_pkg::EV_ABORTED || event_res == fss_pkg::EV_LAST)
      |-> !running)
    else $error("sweep still running after abort or last point");

  a_setpoint_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnet_setpoint <= fss_pkg::V_MAX[9:0])
    else $error("setpoint above clamp");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == fss_pkg::ST_IDLE |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res))
    else $error("pending result item changed");

endmodule
